// ===== hw/rtl/hrdp_pkg.sv =====
package hrdp_pkg;

  // Sizing
  localparam int USAGE_DEPTH = 16;
  localparam int MAX_COUNT   = 64;

  localparam int QPTR_W = (USAGE_DEPTH > 1) ? $clog2(USAGE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(USAGE_DEPTH + 1);
  localparam int SLOT_W = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int CNT_W  = $clog2(MAX_COUNT + 1);

  // Item prefix codes
  localparam logic [7:0] TAG_MASK         = 8'hFC;
  localparam logic [7:0] LONG_PREFIX      = 8'hFE;
  localparam logic [7:0] TAG_INPUT        = 8'h80;
  localparam logic [7:0] TAG_OUTPUT       = 8'h90;
  localparam logic [7:0] TAG_COLLECTION   = 8'hA0;
  localparam logic [7:0] TAG_USAGE_PAGE   = 8'h04;
  localparam logic [7:0] TAG_REPORT_SIZE  = 8'h74;
  localparam logic [7:0] TAG_REPORT_COUNT = 8'h94;
  localparam logic [7:0] TAG_USAGE        = 8'h08;
  localparam logic [7:0] TAG_USAGE_MIN    = 8'h18;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LONG  = 2'd1,
    ERR_CLAMP = 2'd2
  } err_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // frame the incoming byte
    logic clear;     // return all parser state to reset
    logic apply;     // execute a non-main item
    logic slot_clr;  // start a main item's slot walk
    logic step;      // process one report slot
    logic emit_err;  // emit the long item error result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic long_prefix;  // incoming byte is a long item prefix
    logic frame_done;   // incoming byte completes a short item
    logic is_main;      // framed item is Input or Output
    logic no_slot;      // report count is zero
    logic slot_last;    // current slot is the item's last
    logic out_free;     // output register can take a result
  } status_t;

  // Number of data bytes following a short item prefix
  function automatic logic [2:0] total_bytes(input logic [7:0] prefix);
    logic [2:0] n;
    n = (prefix[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix[1:0]};
    return n;
  endfunction

endpackage

// ===== hw/rtl/hrdp_ctrl.sv =====
module hrdp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             final_byte_i,
  input  hrdp_pkg::status_t sts_i,
  output hrdp_pkg::cmd_t   cmd_o
);
  import hrdp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MAIN,
    ST_ERR
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          fin_d        = final_byte_i;
          if (sts_i.long_prefix) begin
            state_d = ST_ERR;
          end else if (sts_i.frame_done) begin
            state_d = ST_EXEC;
          end else begin
            cmd_o.clear = final_byte_i;
          end
        end
      end
      ST_EXEC: begin
        if (sts_i.is_main && !sts_i.no_slot) begin
          cmd_o.slot_clr = 1'b1;
          state_d        = ST_MAIN;
        end else begin
          cmd_o.apply = !sts_i.is_main;
          cmd_o.clear = fin_q;
          state_d     = ST_IDLE;
        end
      end
      ST_MAIN: begin
        cmd_o.step = sts_i.out_free;
        if (sts_i.out_free && sts_i.slot_last) begin
          cmd_o.clear = fin_q;
          state_d     = ST_IDLE;
        end
      end
      ST_ERR: begin
        cmd_o.emit_err = sts_i.out_free;
        if (sts_i.out_free) begin
          cmd_o.clear = fin_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ===== hw/rtl/hrdp_dp.sv =====
module hrdp_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        desc_byte_i,
  input  hrdp_pkg::cmd_t    cmd_i,
  output hrdp_pkg::status_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_output_report_o,
  output logic [31:0]       field_usage_o,
  output logic [15:0]       field_bit_offset_o,
  output logic [7:0]        field_bit_length_o,
  output logic              is_index_o,
  output logic [1:0]        error_code_o,
  output logic              last_of_item_o
);
  import hrdp_pkg::*;

  // Framing and parser state
  logic [7:0]        prefix_q;
  logic [2:0]        left_q;
  logic [31:0]       data_q;
  logic [7:0]        page_q;
  logic [7:0]        size_q;
  logic [31:0]       count_q;
  logic [15:0]       min_q;
  logic [15:0]       in_off_q;
  logic [15:0]       out_off_q;
  logic [QPTR_W-1:0] qhead_q;
  logic [QCNT_W-1:0] qcnt_q;
  logic [31:0]       queue_q [USAGE_DEPTH];
  logic [SLOT_W-1:0] slot_q;

  // Output register
  logic        out_valid_q;
  logic        o_is_out_q;
  logic [31:0] o_usage_q;
  logic [15:0] o_off_q;
  logic [7:0]  o_len_q;
  logic        o_idx_q;
  err_e        o_err_q;
  logic        o_last_q;

  // Item decode
  logic [7:0]        tag;
  logic              is_out_item;
  logic              clamped;
  logic              constant;
  logic              variable;
  logic [CNT_W-1:0]  cnt_eff;
  logic              slot_last;
  logic [15:0]       cur_off;
  logic [31:0]       usage_raw;
  logic [31:0]       usage_field;
  logic              q_empty;
  logic              q_full;
  logic [QCNT_W:0]   wr_sum;
  logic [QPTR_W-1:0] wr_idx;
  logic [QPTR_W-1:0] head_nxt;
  logic [1:0]        lane;
  logic              out_free;
  logic              load_field;
  logic              load_clamp;

  assign tag         = prefix_q & TAG_MASK;
  assign is_out_item = (tag == TAG_OUTPUT);
  assign clamped     = (count_q > 32'(MAX_COUNT));
  assign constant    = data_q[0];
  assign variable    = data_q[1];
  assign cnt_eff     = clamped ? CNT_W'(MAX_COUNT) : count_q[CNT_W-1:0];
  assign slot_last   = (CNT_W'(slot_q) == (cnt_eff - CNT_W'(1)));
  assign cur_off     = is_out_item ? out_off_q : in_off_q;
  assign q_empty     = (qcnt_q == '0);
  assign q_full      = (qcnt_q == QCNT_W'(USAGE_DEPTH));
  assign usage_raw   = (variable && !q_empty) ? queue_q[qhead_q] : {16'h0000, min_q};
  assign usage_field = usage_raw | {8'h00, page_q, 16'h0000};

  // Circular queue pointers
  assign wr_sum   = (QCNT_W + 1)'(qhead_q) + (QCNT_W + 1)'(qcnt_q);
  assign wr_idx   = (wr_sum >= (QCNT_W + 1)'(USAGE_DEPTH))
                    ? QPTR_W'(wr_sum - (QCNT_W + 1)'(USAGE_DEPTH)) : QPTR_W'(wr_sum);
  assign head_nxt = (qhead_q == QPTR_W'(USAGE_DEPTH - 1)) ? '0 : qhead_q + QPTR_W'(1);

  // Byte lane of the next data byte
  assign lane = 2'(total_bytes(prefix_q) - left_q);

  assign out_free   = !out_valid_q || out_ready_i;
  assign load_field = cmd_i.step && !constant;
  assign load_clamp = cmd_i.step && constant && clamped && slot_last;

  // Status back to the controller
  always_comb begin
    sts_o.long_prefix = (left_q == 3'd0) && (desc_byte_i == LONG_PREFIX);
    sts_o.frame_done  = (left_q == 3'd0)
                        ? ((desc_byte_i != LONG_PREFIX) && (total_bytes(desc_byte_i) == 3'd0))
                        : (left_q == 3'd1);
    sts_o.is_main     = (tag == TAG_INPUT) || (tag == TAG_OUTPUT);
    sts_o.no_slot     = (count_q == 32'd0);
    sts_o.slot_last   = slot_last;
    sts_o.out_free    = out_free;
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q  <= '0;
      left_q    <= '0;
      data_q    <= '0;
      page_q    <= '0;
      size_q    <= '0;
      count_q   <= '0;
      min_q     <= '0;
      in_off_q  <= '0;
      out_off_q <= '0;
      qhead_q   <= '0;
      qcnt_q    <= '0;
      slot_q    <= '0;
    end else if (cmd_i.clear) begin
      prefix_q  <= '0;
      left_q    <= '0;
      data_q    <= '0;
      page_q    <= '0;
      size_q    <= '0;
      count_q   <= '0;
      min_q     <= '0;
      in_off_q  <= '0;
      out_off_q <= '0;
      qhead_q   <= '0;
      qcnt_q    <= '0;
      slot_q    <= '0;
    end else begin
      // Item framing
      if (cmd_i.accept) begin
        if (left_q == 3'd0) begin
          if (desc_byte_i != LONG_PREFIX) begin
            prefix_q <= desc_byte_i;
            data_q   <= '0;
            left_q   <= total_bytes(desc_byte_i);
          end
        end else begin
          case (lane)
            2'd0:    data_q[7:0]   <= desc_byte_i;
            2'd1:    data_q[15:8]  <= desc_byte_i;
            2'd2:    data_q[23:16] <= desc_byte_i;
            default: data_q[31:24] <= desc_byte_i;
          endcase
          left_q <= left_q - 3'd1;
        end
      end

      // Global, local and collection items
      if (cmd_i.apply) begin
        case (tag)
          TAG_COLLECTION:   qcnt_q  <= '0;
          TAG_USAGE_PAGE:   page_q  <= data_q[7:0];
          TAG_REPORT_SIZE:  size_q  <= data_q[7:0];
          TAG_REPORT_COUNT: count_q <= data_q;
          TAG_USAGE_MIN:    min_q   <= data_q[15:0];
          TAG_USAGE: begin
            if (!q_full) begin
              qcnt_q <= qcnt_q + QCNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end

      // Report slot walk
      if (cmd_i.slot_clr) begin
        slot_q <= '0;
      end else if (cmd_i.step) begin
        slot_q <= slot_q + SLOT_W'(1);
        if (is_out_item) begin
          out_off_q <= out_off_q + 16'(size_q);
        end else begin
          in_off_q <= in_off_q + 16'(size_q);
        end
        if (!constant && variable) begin
          if (q_empty) begin
            min_q <= min_q + 16'd1;
          end else begin
            qhead_q <= head_nxt;
            qcnt_q  <= qcnt_q - QCNT_W'(1);
          end
        end
      end
    end
  end

  // Usage queue storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && (tag == TAG_USAGE) && !q_full) begin
      queue_q[wr_idx] <= data_q;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_field || load_clamp || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load_field) begin
      o_is_out_q <= is_out_item;
      o_usage_q  <= usage_field;
      o_off_q    <= cur_off;
      o_len_q    <= size_q;
      o_idx_q    <= !variable;
      o_err_q    <= clamped ? ERR_CLAMP : ERR_NONE;
      o_last_q   <= slot_last;
    end else if (load_clamp) begin
      o_is_out_q <= is_out_item;
      o_usage_q  <= '0;
      o_off_q    <= '0;
      o_len_q    <= '0;
      o_idx_q    <= 1'b0;
      o_err_q    <= ERR_CLAMP;
      o_last_q   <= 1'b1;
    end else if (cmd_i.emit_err) begin
      o_is_out_q <= 1'b0;
      o_usage_q  <= '0;
      o_off_q    <= '0;
      o_len_q    <= '0;
      o_idx_q    <= 1'b0;
      o_err_q    <= ERR_LONG;
      o_last_q   <= 1'b1;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign is_output_report_o = o_is_out_q;
  assign field_usage_o      = o_usage_q;
  assign field_bit_offset_o = o_off_q;
  assign field_bit_length_o = o_len_q;
  assign is_index_o         = o_idx_q;
  assign error_code_o       = o_err_q;
  assign last_of_item_o     = o_last_q;

endmodule

// ===== hw/rtl/hid_report_descriptor_parser_core.sv =====
// HID report descriptor parser.
// Input channel (in_valid_i/in_ready_o): one descriptor byte per transaction,
// final_byte_i marks the last byte; after it the parser returns to reset state.
// Output channel (out_valid_o/out_ready_i): one field record per transaction,
// held in an output register so a waiting result does not block the input.
// Sequencing: a byte that does not finish an item leaves the controller idle.
// A finished global or local item passes through the execute state. A finished
// Input or Output item passes through the execute state, then walks its report
// slots (report count, at most MAX_COUNT) in the controller's slot walk. A long
// item prefix yields one error record.
// In ready is high only while the controller is idle.
// When the receiver stalls, the slot walk halts until the output register is
// taken; the input side then stays not ready.
// Reset (rst_ni low, asynchronous) clears all parser state and the output
// valid; the usage queue contents are not cleared, only its fill count.
module hid_report_descriptor_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  desc_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_output_report_o,
  output logic [31:0] field_usage_o,
  output logic [15:0] field_bit_offset_o,
  output logic [7:0]  field_bit_length_o,
  output logic        is_index_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_item_o
);
  import hrdp_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Sequencer
  hrdp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .final_byte_i (final_byte_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Parser state and field record datapath
  hrdp_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .desc_byte_i        (desc_byte_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .is_output_report_o (is_output_report_o),
    .field_usage_o      (field_usage_o),
    .field_bit_offset_o (field_bit_offset_o),
    .field_bit_length_o (field_bit_length_o),
    .is_index_o         (is_index_o),
    .error_code_o       (error_code_o),
    .last_of_item_o     (last_of_item_o)
  );

endmodule

// ===== dv/hrdp_field_checker.sv =====
module hrdp_field_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // descriptor byte channel
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  desc_byte_i,
  input  logic        final_byte_i,
  // field record channel
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        is_output_report_i,
  input  logic [31:0] field_usage_i,
  input  logic [15:0] field_bit_offset_i,
  input  logic [7:0]  field_bit_length_i,
  input  logic        is_index_i,
  input  logic [1:0]  error_code_i,
  input  logic        last_of_item_i,
  // status for the test top
  output int unsigned error_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hrdp_pkg::*;

  typedef struct packed {
    logic        is_out;
    logic [31:0] usage;
    logic [15:0] offset;
    logic [7:0]  bit_len;
    logic        is_index;
    err_e        err;
    logic        last;
  } field_rec_t;

  // Field records still owed by the block, oldest first
  field_rec_t expected_fields[$];
  int unsigned mismatches;

  // Parser model state
  logic [7:0]  cur_prefix;
  logic [2:0]  bytes_left;
  logic [31:0] cur_data;
  logic [7:0]  page;
  logic [7:0]  rsize;
  logic [31:0] rcount;
  logic [31:0] usages[$];
  logic [15:0] umin;
  logic [15:0] in_off;
  logic [15:0] out_off;

  function automatic logic [2:0] data_len(input logic [7:0] prefix);
    logic [2:0] n;
    case (prefix[1:0])
      2'd0:    n = 3'd0;
      2'd1:    n = 3'd1;
      2'd2:    n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  task automatic clear_model();
    cur_prefix = '0;
    bytes_left = '0;
    cur_data   = '0;
    page       = '0;
    rsize      = '0;
    rcount     = '0;
    usages.delete();
    umin       = '0;
    in_off     = '0;
    out_off    = '0;
  endtask

  // Walk the report slots of an Input or Output item
  task automatic walk_report_slots(input logic is_out);
    field_rec_t item_recs[$];
    field_rec_t r;
    logic [31:0] slots;
    logic [31:0] u;
    logic [15:0] off;
    logic clamp;
    logic konst;
    logic var_item;
    clamp    = rcount > MAX_COUNT;
    slots    = clamp ? 32'(MAX_COUNT) : rcount;
    konst    = cur_data[0];
    var_item = cur_data[1];
    off      = is_out ? out_off : in_off;
    for (int unsigned i = 0; i < slots; i++) begin
      if (!konst) begin
        if (!var_item) begin
          u = 32'(umin);
        end else if (usages.size() == 0) begin
          u = 32'(umin);
          umin = umin + 16'd1;
        end else begin
          u = usages.pop_front();
        end
        r          = '0;
        r.is_out   = is_out;
        r.usage    = u | (32'(page) << 16);
        r.offset   = off;
        r.bit_len  = rsize;
        r.is_index = !var_item;
        r.err      = clamp ? ERR_CLAMP : ERR_NONE;
        item_recs.insert(item_recs.size(), r);
      end
      off = off + 16'(rsize);
    end
    if (is_out) out_off = off;
    else in_off = off;
    // last flag on the final field; a clamped constant item still reports
    if (item_recs.size() > 0) begin
      r = item_recs[item_recs.size() - 1];
      r.last = 1'b1;
      item_recs[item_recs.size() - 1] = r;
    end else if (clamp) begin
      r        = '0;
      r.is_out = is_out;
      r.err    = ERR_CLAMP;
      r.last   = 1'b1;
      item_recs.insert(item_recs.size(), r);
    end
    foreach (item_recs[k]) expected_fields.insert(expected_fields.size(), item_recs[k]);
  endtask

  task automatic apply_item();
    case (cur_prefix & TAG_MASK)
      TAG_INPUT:        walk_report_slots(1'b0);
      TAG_OUTPUT:       walk_report_slots(1'b1);
      TAG_COLLECTION:   usages.delete();
      TAG_USAGE_PAGE:   page = cur_data[7:0];
      TAG_REPORT_SIZE:  rsize = cur_data[7:0];
      TAG_REPORT_COUNT: rcount = cur_data;
      TAG_USAGE: begin
        // a full queue drops the new usage
        if (usages.size() < USAGE_DEPTH) usages.insert(usages.size(), cur_data);
      end
      TAG_USAGE_MIN:    umin = cur_data[15:0];
      default: ;
    endcase
  endtask

  task automatic parse_desc_byte(input logic [7:0] b, input logic fin);
    field_rec_t r;
    logic [2:0] idx;
    if (bytes_left == 3'd0) begin
      if (b == LONG_PREFIX) begin
        r      = '0;
        r.err  = ERR_LONG;
        r.last = 1'b1;
        expected_fields.insert(expected_fields.size(), r);
      end else begin
        cur_prefix = b;
        cur_data   = '0;
        bytes_left = data_len(b);
        if (bytes_left == 3'd0) apply_item();
      end
    end else begin
      // data bytes arrive least significant first
      idx        = data_len(cur_prefix) - bytes_left;
      cur_data   = cur_data | (32'(b) << (8 * idx[1:0]));
      bytes_left = bytes_left - 3'd1;
      if (bytes_left == 3'd0) apply_item();
    end
    if (fin) clear_model();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_field();
    field_rec_t want;
    if (expected_fields.size() == 0) begin
      report_mismatch("unexpected field record", '0, field_usage_i);
      return;
    end
    want = expected_fields.pop_front();
    if (is_output_report_i !== want.is_out)
      report_mismatch("is_output_report", 32'(want.is_out), 32'(is_output_report_i));
    if (field_usage_i !== want.usage)
      report_mismatch("field_usage", want.usage, field_usage_i);
    if (field_bit_offset_i !== want.offset)
      report_mismatch("field_bit_offset", 32'(want.offset), 32'(field_bit_offset_i));
    if (field_bit_length_i !== want.bit_len)
      report_mismatch("field_bit_length", 32'(want.bit_len), 32'(field_bit_length_i));
    if (is_index_i !== want.is_index)
      report_mismatch("is_index", 32'(want.is_index), 32'(is_index_i));
    if (error_code_i !== want.err)
      report_mismatch("error_code", 32'(want.err), 32'(error_code_i));
    if (last_of_item_i !== want.last)
      report_mismatch("last_of_item", 32'(want.last), 32'(last_of_item_i));
  endtask

  // Outputs are compared before the byte of the same edge is modeled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      expected_fields.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_field();
      if (in_valid_i && in_ready_i) parse_desc_byte(desc_byte_i, final_byte_i);
      pending_o <= expected_fields.size();
    end
    error_count_o <= mismatches;
  end

  initial mismatches = 0;

endmodule

// ===== dv/hid_report_descriptor_parser_core_test.sv =====
module hid_report_descriptor_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hrdp_pkg::*;

  localparam int ITEM_TARGET    = 330;
  localparam int HOLD_CYCLES    = 250;
  localparam int DRAIN_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  desc_byte_i  = 8'h00;
  logic        final_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        is_output_report_o;
  logic [31:0] field_usage_o;
  logic [15:0] field_bit_offset_o;
  logic [7:0]  field_bit_length_o;
  logic        is_index_o;
  logic [1:0]  error_code_o;
  logic        last_of_item_o;

  int unsigned mismatches;
  int unsigned fields_pending;
  int unsigned fields_taken = 0;
  int unsigned idle_cycles  = 0;
  bit          stim_done    = 1'b0;
  bit          draining     = 1'b0;

  // {final flag, byte} in send order
  logic [8:0] desc_stream[$];

  hid_report_descriptor_parser_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .desc_byte_i        (desc_byte_i),
    .final_byte_i       (final_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .is_output_report_o (is_output_report_o),
    .field_usage_o      (field_usage_o),
    .field_bit_offset_o (field_bit_offset_o),
    .field_bit_length_o (field_bit_length_o),
    .is_index_o         (is_index_o),
    .error_code_o       (error_code_o),
    .last_of_item_o     (last_of_item_o)
  );

  hrdp_field_checker i_field_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .desc_byte_i        (desc_byte_i),
    .final_byte_i       (final_byte_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .is_output_report_i (is_output_report_o),
    .field_usage_i      (field_usage_o),
    .field_bit_offset_i (field_bit_offset_o),
    .field_bit_length_i (field_bit_length_o),
    .is_index_i         (is_index_o),
    .error_code_i       (error_code_o),
    .last_of_item_i     (last_of_item_o),
    .error_count_o      (mismatches),
    .pending_o          (fields_pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic put_byte(input logic [7:0] b);
    desc_stream.insert(desc_stream.size(), {1'b0, b});
  endtask

  // Short item: prefix plus 0, 1, 2 or 4 data bytes, little-endian
  task automatic put_item(input logic [7:0] tag, input logic [1:0] sz,
                          input logic [31:0] value);
    int nbytes;
    nbytes = (sz == 2'd3) ? 4 : int'(sz);
    put_byte((tag & TAG_MASK) | {6'd0, sz});
    for (int k = 0; k < nbytes; k++) put_byte(value[8*k +: 8]);
  endtask

  task automatic end_descriptor();
    logic [8:0] b;
    b = desc_stream[desc_stream.size() - 1];
    b[8] = 1'b1;
    desc_stream[desc_stream.size() - 1] = b;
  endtask

  function automatic logic [1:0] rand_size();
    return 2'($urandom_range(0, 3));
  endfunction

  // Random descriptor: mostly well-formed items, some noise and truncation
  task automatic add_descriptor();
    logic [31:0] cnt;
    int n_items;
    n_items = $urandom_range(3, 24);
    put_item(TAG_USAGE_PAGE, 2'd1, $urandom);
    repeat (n_items) begin
      case ($urandom_range(0, 19))
        0, 1: put_item(TAG_USAGE_PAGE, rand_size(), $urandom);
        2, 3: begin
          cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 16);
          put_item(TAG_REPORT_SIZE, rand_size(), cnt);
        end
        4, 5: begin
          case ($urandom_range(0, 19))
            0:          cnt = $urandom;
            1:          cnt = $urandom_range(65, 90);
            2, 3, 4, 5: cnt = $urandom_range(9, 64);
            default:    cnt = $urandom_range(0, 8);
          endcase
          put_item(TAG_REPORT_COUNT, (cnt > 255) ? 2'd3 : 2'($urandom_range(1, 3)), cnt);
        end
        6, 7, 8: put_item(TAG_USAGE, rand_size(), $urandom);
        9:       put_item(TAG_USAGE_MIN, rand_size(), $urandom);
        10:      put_item(TAG_COLLECTION, 2'd1, $urandom_range(0, 2));
        11, 12, 13: put_item(TAG_INPUT, rand_size(), $urandom);
        14, 15:  put_item(TAG_OUTPUT, rand_size(), $urandom);
        16:      put_byte(LONG_PREFIX);
        17:      put_item(8'($urandom), rand_size(), $urandom);
        18: begin
          // overfill the usage queue, then drain it with a variable item
          repeat ($urandom_range(14, 20)) put_item(TAG_USAGE, 2'd1, $urandom);
          put_item(TAG_REPORT_COUNT, 2'd1, $urandom_range(14, 20));
          put_item($urandom_range(0, 1) ? TAG_OUTPUT : TAG_INPUT, 2'd1, 32'h2);
        end
        default: repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      endcase
    end
    // sometimes the descriptor ends inside an item
    if ($urandom_range(0, 7) == 0) begin
      put_byte(TAG_USAGE | 8'h03);
      put_byte(8'($urandom));
    end
    end_descriptor();
  endtask

  // Directed descriptor, then random ones
  initial begin
    put_byte(LONG_PREFIX);
    put_item(TAG_USAGE_PAGE, 2'd1, 32'h07);
    put_item(TAG_REPORT_SIZE, 2'd1, 32'hFF);
    put_item(TAG_REPORT_COUNT, 2'd3, 32'd65);
    put_item(TAG_INPUT, 2'd1, 32'h01);         // clamped constant item
    put_item(TAG_OUTPUT, 2'd1, 32'h02);        // clamped variable item
    put_item(TAG_USAGE_MIN, 2'd2, 32'hFFFE);
    put_item(TAG_COLLECTION, 2'd1, 32'h01);
    put_item(TAG_USAGE, 2'd3, 32'h12345678);
    put_item(TAG_REPORT_COUNT, 2'd1, 32'd3);
    put_item(TAG_OUTPUT, 2'd1, 32'h02);        // queue, then usage min wrap
    put_item(TAG_INPUT, 2'd1, 32'h00);         // array item
    put_item(TAG_REPORT_COUNT, 2'd0, 32'd0);
    put_item(TAG_INPUT, 2'd0, 32'd0);          // no slot
    put_byte(TAG_USAGE_PAGE | 8'h02);
    put_byte(8'h34);                           // final byte mid-item
    end_descriptor();
    while (desc_stream.size() < ITEM_TARGET) add_descriptor();
  end

  // Byte sender: bursts with random gaps
  initial begin : sender
    logic [8:0] nxt;
    int burst;
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    while (desc_stream.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && desc_stream.size() > 0) begin
        nxt = desc_stream.pop_front();
        in_valid_i   <= 1'b1;
        desc_byte_i  <= nxt[7:0];
        final_byte_i <= nxt[8];
        @(posedge clk_i);
        while (!in_ready_o) @(posedge clk_i);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) fields_taken <= fields_taken + 1;
  end

  // Record receiver: stall pattern in random modes, one long hold-off
  initial begin : receiver
    int mode;
    int span;
    bit held;
    mode = 0;
    span = 0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (draining) begin
        out_ready_i <= 1'b1;
      end else if (!held && fields_taken >= 40) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(5, 60);
        end
        span--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Reset, drain and verdict
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done);
    @(posedge clk_i);
    draining <= 1'b1;
    while (fields_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && fields_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hrdp_pkg.sv
hw/rtl/hrdp_ctrl.sv
hw/rtl/hrdp_dp.sv
hw/rtl/hid_report_descriptor_parser_core.sv
dv/hrdp_field_checker.sv
dv/hid_report_descriptor_parser_core_test.sv
